/* rtl/pbrq_pkg.sv */
package pbrq_pkg;

    localparam int KIND_W   = 2;
    localparam int TID_W    = 6;
    localparam int PRIO_W   = 5;
    localparam int STATUS_W = 2;

    // levels that a priority field can address
    localparam int PRIO_LEVELS_MAX = 2 ** PRIO_W;

    localparam int PRIORITY_LEVELS_DEF = 32;
    localparam int MAX_THREADS_DEF     = 64;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PICK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP_ADD   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_THREAD = 2'd2;

endpackage

/* rtl/pbrq_find_first.sv */
module pbrq_find_first #(
    parameter int WIDTH = 32,
    localparam int IDX_W = $clog2(WIDTH)
) (
    input  logic [WIDTH-1:0] req,
    output logic             found,
    output logic [IDX_W-1:0] idx
);

    // lowest set bit wins
    always_comb begin
        idx = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (req[i]) begin
                idx = IDX_W'(i);
            end
        end
    end

    assign found = |req;

endmodule

/* rtl/priority_bitmap_ready_queue_scheduler.sv */
// Ready-queue scheduler with one linked FIFO of thread ids per priority level, a count
// per level and a bitmap of non-empty levels. Add puts a thread at the head of its level,
// remove unlinks it, pick returns the head of the lowest-numbered non-empty level and
// rotates it to the tail, or the idle thread from cfg_idle_thread_id when nothing is
// ready. Every item gives exactly one result. An item first reads the link memories (next
// link, previous link, level of the thread), whose read data is registered, then updates
// the queues and loads the result register once no earlier result waits on m_ready. A new
// item is accepted once the previous one has updated the queues, even while its result
// still waits on m_ready. Priorities beyond the last level are saturated to it.
// No clearing pass runs after reset; the block accepts items from the first cycle.
// cfg_idle_thread_id may only be written while the block is idle.
module priority_bitmap_ready_queue_scheduler
    import pbrq_pkg::*;
#(
    parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
    parameter int MAX_THREADS     = MAX_THREADS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TID_W-1:0]    cfg_idle_thread_id,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [TID_W-1:0]    s_thread_id,
    input  logic [PRIO_W-1:0]   s_priority_req,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [TID_W-1:0]    m_chosen_thread,
    output logic                m_is_idle,
    output logic                m_switch_needed,
    output logic [STATUS_W-1:0] m_status
);

    localparam int NUM_LVL = (PRIORITY_LEVELS < PRIO_LEVELS_MAX) ? PRIORITY_LEVELS
                                                                 : PRIO_LEVELS_MAX;
    localparam int LW = $clog2(NUM_LVL);
    localparam int TW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic accept;
    logic commit;

    logic [KIND_W-1:0] kind_reg;
    logic [TID_W-1:0]  tid_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [LW-1:0]     pick_lvl_reg;
    logic              pick_any_reg;

    logic [TID_W-1:0] idle_id_reg;
    logic [TID_W-1:0] cur_thread_reg;

    logic [NUM_LVL-1:0] bitmap_reg;
    logic [CW-1:0]      count_reg [NUM_LVL];
    logic [TW-1:0]      head_reg  [NUM_LVL];
    logic [TW-1:0]      tail_reg  [NUM_LVL];
    logic [MAX_THREADS-1:0] rdy_reg;

    logic [TW-1:0] next_link_mem [MAX_THREADS];
    logic [TW-1:0] prev_link_mem [MAX_THREADS];
    logic [LW-1:0] level_mem     [MAX_THREADS];
    logic [TW-1:0] nl_rd_reg;
    logic [TW-1:0] pl_rd_reg;
    logic [LW-1:0] lv_rd_reg;

    logic              m_valid_reg, m_valid_next;
    logic [TID_W-1:0]  chosen_reg;
    logic              idle_flag_reg;
    logic              switch_reg;
    logic [STATUS_W-1:0] status_reg;

    logic          enc_found;
    logic [LW-1:0] enc_idx;

    logic [TW-1:0] s_tid_idx;
    logic [TW-1:0] nl_ra;
    logic [TW-1:0] t_idx;
    logic          tid_ok;
    logic [LW-1:0] add_lvl;
    logic [LW-1:0] lvl_op;
    logic [LW-1:0] head_addr;
    logic [TW-1:0] hd;
    logic [TW-1:0] tl;
    logic [CW-1:0] cnt;

    logic [TID_W-1:0]    res_chosen;
    logic                res_idle;
    logic                res_sw;
    logic [STATUS_W-1:0] res_status;

    logic          hd_we, tl_we, cnt_we, bm_set, bm_clr, rdy_we, rdy_wd;
    logic          nl_we, pl_we, lv_we, cur_we;
    logic [TW-1:0] hd_wd, tl_wd, nl_wa, nl_wd, pl_wa, pl_wd;
    logic [CW-1:0] cnt_wd;

    pbrq_find_first #(
        .WIDTH (NUM_LVL)
    ) u_find_first (
        .req   (bitmap_reg),
        .found (enc_found),
        .idx   (enc_idx)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign commit    = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;

    // one read address on the head array: pick level while idle, operation level after
    assign head_addr = (state_reg == ST_IDLE) ? enc_idx : lvl_op;
    assign hd        = head_reg[head_addr];
    assign tl        = tail_reg[lvl_op];
    assign cnt       = count_reg[lvl_op];

    assign s_tid_idx = TW'(s_thread_id);
    assign nl_ra     = (s_kind == KIND_PICK) ? hd : s_tid_idx;

    assign t_idx   = TW'(tid_reg);
    assign tid_ok  = int'(tid_reg) < MAX_THREADS;
    assign add_lvl = (int'(prio_reg) >= NUM_LVL) ? LW'(NUM_LVL - 1) : LW'(prio_reg);

    always_comb begin
        case (kind_reg)
            KIND_ADD:    lvl_op = add_lvl;
            KIND_REMOVE: lvl_op = lv_rd_reg;
            default:     lvl_op = pick_lvl_reg;
        endcase
    end

    always_comb begin
        res_chosen = tid_reg;
        res_idle   = 1'b0;
        res_sw     = 1'b0;
        res_status = STATUS_OK;
        hd_we  = 1'b0;
        hd_wd  = t_idx;
        tl_we  = 1'b0;
        tl_wd  = t_idx;
        cnt_we = 1'b0;
        cnt_wd = cnt;
        bm_set = 1'b0;
        bm_clr = 1'b0;
        rdy_we = 1'b0;
        rdy_wd = 1'b0;
        nl_we  = 1'b0;
        nl_wa  = t_idx;
        nl_wd  = hd;
        pl_we  = 1'b0;
        pl_wa  = hd;
        pl_wd  = t_idx;
        lv_we  = 1'b0;
        cur_we = 1'b0;
        case (kind_reg)
            KIND_ADD: begin
                if (!tid_ok || rdy_reg[t_idx]) begin
                    res_status = STATUS_DUP_ADD;
                end else begin
                    hd_we = 1'b1;
                    hd_wd = t_idx;
                    if (cnt == '0) begin
                        tl_we = 1'b1;
                        tl_wd = t_idx;
                    end else begin
                        nl_we = 1'b1;
                        nl_wa = t_idx;
                        nl_wd = hd;
                        pl_we = 1'b1;
                        pl_wa = hd;
                        pl_wd = t_idx;
                    end
                    cnt_we = 1'b1;
                    cnt_wd = CW'(cnt + 1'b1);
                    bm_set = 1'b1;
                    lv_we  = 1'b1;
                    rdy_we = 1'b1;
                    rdy_wd = 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (!tid_ok || !rdy_reg[t_idx]) begin
                    res_status = STATUS_NO_THREAD;
                end else begin
                    if (hd == t_idx) begin
                        hd_we = 1'b1;
                        hd_wd = nl_rd_reg;
                    end else begin
                        nl_we = 1'b1;
                        nl_wa = pl_rd_reg;
                        nl_wd = nl_rd_reg;
                    end
                    if (tl == t_idx) begin
                        tl_we = 1'b1;
                        tl_wd = pl_rd_reg;
                    end else begin
                        pl_we = 1'b1;
                        pl_wa = nl_rd_reg;
                        pl_wd = pl_rd_reg;
                    end
                    cnt_we = 1'b1;
                    cnt_wd = CW'(cnt - 1'b1);
                    bm_clr = (cnt == CW'(1));
                    rdy_we = 1'b1;
                    rdy_wd = 1'b0;
                end
            end
            KIND_PICK: begin
                cur_we = 1'b1;
                if (!pick_any_reg) begin
                    res_chosen = idle_id_reg;
                    res_idle   = 1'b1;
                end else begin
                    res_chosen = TID_W'(hd);
                    // rotate head to tail
                    if (cnt > CW'(1)) begin
                        hd_we = 1'b1;
                        hd_wd = nl_rd_reg;
                        nl_we = 1'b1;
                        nl_wa = tl;
                        nl_wd = hd;
                        pl_we = 1'b1;
                        pl_wa = hd;
                        pl_wd = tl;
                        tl_we = 1'b1;
                        tl_wd = hd;
                    end
                end
                res_sw = (res_chosen != cur_thread_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (state_reg)
            ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = commit ? ST_IDLE : ST_EXEC;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            idle_id_reg    <= '0;
            cur_thread_reg <= '0;
            bitmap_reg     <= '0;
            rdy_reg        <= '0;
            for (int i = 0; i < NUM_LVL; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                idle_id_reg <= cfg_idle_thread_id;
            end
            if (commit) begin
                if (cur_we) begin
                    cur_thread_reg <= res_chosen;
                end
                if (cnt_we) begin
                    count_reg[lvl_op] <= cnt_wd;
                end
                if (bm_set) begin
                    bitmap_reg[lvl_op] <= 1'b1;
                end
                if (bm_clr) begin
                    bitmap_reg[lvl_op] <= 1'b0;
                end
                if (rdy_we) begin
                    rdy_reg[t_idx] <= rdy_wd;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg     <= s_kind;
            tid_reg      <= s_thread_id;
            prio_reg     <= s_priority_req;
            pick_lvl_reg <= enc_idx;
            pick_any_reg <= enc_found;
        end
        if (commit) begin
            chosen_reg    <= res_chosen;
            idle_flag_reg <= res_idle;
            switch_reg    <= res_sw;
            status_reg    <= res_status;
            if (hd_we) begin
                head_reg[lvl_op] <= hd_wd;
            end
            if (tl_we) begin
                tail_reg[lvl_op] <= tl_wd;
            end
        end
    end

    // link memories
    always_ff @(posedge aclk) begin
        if (commit && nl_we) begin
            next_link_mem[nl_wa] <= nl_wd;
        end
        if (commit && pl_we) begin
            prev_link_mem[pl_wa] <= pl_wd;
        end
        if (commit && lv_we) begin
            level_mem[t_idx] <= lvl_op;
        end
        if (accept) begin
            nl_rd_reg <= next_link_mem[nl_ra];
            pl_rd_reg <= prev_link_mem[s_tid_idx];
            lv_rd_reg <= level_mem[s_tid_idx];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_chosen_thread = chosen_reg;
    assign m_is_idle       = idle_flag_reg;
    assign m_switch_needed = switch_reg;
    assign m_status        = status_reg;

`ifndef SYNTHESIS
    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid)
        else $error("result not presented after commit");

    a_idle_pick_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && kind_reg == KIND_PICK && !pick_any_reg) |-> (bitmap_reg == '0))
        else $error("idle pick while a level is ready");

    a_pick_level_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && kind_reg == KIND_PICK && pick_any_reg)
            |-> (bitmap_reg[pick_lvl_reg] && count_reg[pick_lvl_reg] != '0))
        else $error("picked level is empty");

    a_add_marks_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && kind_reg == KIND_ADD && res_status == STATUS_OK)
            |=> ($countones(rdy_reg) == $past($countones(rdy_reg)) + 1))
        else $error("add did not mark exactly one thread ready");
`endif

endmodule
